>>> rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared widths, register indexes, reset values and region codes for the
// three-stop colormap core.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int SampleW       = 16;
  localparam int ColorW        = 24;
  localparam int ChanW         = 8;
  localparam int NumChan       = 3;
  localparam int CfgIdxW       = 3;
  localparam int RegionW       = 2;

  localparam int FracW         = 17;
  localparam int DenW          = 16;
  localparam int RemW          = 17;
  localparam int DivSteps      = 17;
  localparam int StepsPerStage = 2;
  localparam int DivStages     = (DivSteps + StepsPerStage - 1) / StepsPerStage;

  localparam int DeltaW        = ChanW + 1;
  localparam int ProdW         = DeltaW + FracW + 1;
  localparam int SumW          = ProdW - 16 + 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_VALUE  = 3'd0,
    REG_MAX_VALUE  = 3'd1,
    REG_LOW_COLOR  = 3'd2,
    REG_MID_COLOR  = 3'd3,
    REG_HIGH_COLOR = 3'd4
  } cfg_reg_t;

  typedef enum logic [RegionW-1:0] {
    REGION_LOW   = 2'd0,
    REGION_LOWER = 2'd1,
    REGION_UPPER = 2'd2,
    REGION_HIGH  = 2'd3
  } region_t;

  localparam logic signed [SampleW-1:0] MinReset  = -16'sd2304;
  localparam logic signed [SampleW-1:0] MaxReset  = 16'sd2304;
  localparam logic [ColorW-1:0]         LowReset  = 24'h0000FF;
  localparam logic [ColorW-1:0]         MidReset  = 24'hFFFFFF;
  localparam logic [ColorW-1:0]         HighReset = 24'hFF0000;

endpackage

>>> rtl/three_stop_colormap_core.sv
// ----------------------------------------------------------------------------
// three_stop_colormap_core
// Diverging pseudo-color map: a signed Q8.8 sample is placed between three
// color stops and each RGB channel is linearly interpolated.
//
//   channel  ports                                   transaction
//   -------  --------------------------------------  ------------------------
//   input    start, busy, in_sample_value            start & !busy
//   result   out_valid, out_red/green/blue/region    out_valid, one cycle
//   config   cfg_valid, cfg_ready, cfg_index/data    cfg_valid & cfg_ready
//
// One sample enters every cycle; busy stays low. Each result passes the input
// register, two range stages, nine stages of a two-bit-per-stage restoring
// divider for the Q1.16 fraction, a multiply stage and the output register.
// Reset is synchronous, clears the valid chain and loads the configuration
// registers with their reset values. The receiver cannot stall, so the
// pipeline never holds.
// ----------------------------------------------------------------------------
module three_stop_colormap_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tsc_pkg::SampleW-1:0]   in_sample_value,
  output logic                                 out_valid,
  output logic [tsc_pkg::ChanW-1:0]            out_red,
  output logic [tsc_pkg::ChanW-1:0]            out_green,
  output logic [tsc_pkg::ChanW-1:0]            out_blue,
  output logic [tsc_pkg::RegionW-1:0]          out_region,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tsc_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [tsc_pkg::ColorW-1:0]           cfg_data
);
  import tsc_pkg::*;

  logic signed [SampleW-1:0] min_r;
  logic signed [SampleW-1:0] max_r;
  logic [ColorW-1:0]         low_r;
  logic [ColorW-1:0]         mid_r;
  logic [ColorW-1:0]         high_r;

  logic                      s0_vld_r;
  logic signed [SampleW-1:0] s0_val_r;

  logic                      s1_vld_r;
  logic                      s1_low_r;
  logic                      s1_high_r;
  logic [SampleW-1:0]        s1_diff_r;
  logic [SampleW-1:0]        s1_dmin_r;

  logic                      div_vld_r  [0:DivStages];
  logic [RemW-1:0]           div_rem_r  [0:DivStages];
  logic [FracW-1:0]          div_quo_r  [0:DivStages];
  logic [DenW-1:0]           div_den_r  [0:DivStages];
  logic                      div_bit_r  [0:DivStages];
  region_t                   div_reg_r  [0:DivStages];

  logic                      mul_vld_r;
  region_t                   mul_reg_r;
  logic signed [ProdW-1:0]   mul_prod_r [0:NumChan-1];
  logic signed [ProdW-1:0]   mul_prod_nxt [0:NumChan-1];

  logic                      out_vld_r;
  logic [ChanW-1:0]          out_chan_r [0:NumChan-1];
  logic [ChanW-1:0]          out_chan_nxt [0:NumChan-1];
  region_t                   out_reg_r;

  logic signed [SampleW:0]   diff_ext;
  logic signed [SampleW:0]   dmin_ext;
  logic [SampleW-1:0]        d_lo;
  logic [SampleW-1:0]        d_hi;
  logic [SampleW-1:0]        d_up;
  logic                      le_mid;
  region_t                   s2_region;

  function automatic logic [ColorW-1:0] color_c0(input region_t rg,
                                                 input logic [ColorW-1:0] lo_c,
                                                 input logic [ColorW-1:0] mi_c,
                                                 input logic [ColorW-1:0] hi_c);
    logic [ColorW-1:0] c;
    case (rg)
      REGION_LOW:   c = lo_c;
      REGION_LOWER: c = lo_c;
      REGION_UPPER: c = mi_c;
      REGION_HIGH:  c = hi_c;
      default:      c = lo_c;
    endcase
    return c;
  endfunction

  function automatic logic [ColorW-1:0] color_c1(input region_t rg,
                                                 input logic [ColorW-1:0] lo_c,
                                                 input logic [ColorW-1:0] mi_c,
                                                 input logic [ColorW-1:0] hi_c);
    logic [ColorW-1:0] c;
    case (rg)
      REGION_LOW:   c = lo_c;
      REGION_LOWER: c = mi_c;
      REGION_UPPER: c = hi_c;
      REGION_HIGH:  c = hi_c;
      default:      c = lo_c;
    endcase
    return c;
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MinReset;
      max_r  <= MaxReset;
      low_r  <= LowReset;
      mid_r  <= MidReset;
      high_r <= HighReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_VALUE:  min_r  <= $signed(cfg_data[SampleW-1:0]);
        REG_MAX_VALUE:  max_r  <= $signed(cfg_data[SampleW-1:0]);
        REG_LOW_COLOR:  low_r  <= cfg_data;
        REG_MID_COLOR:  mid_r  <= cfg_data;
        REG_HIGH_COLOR: high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
    s0_val_r <= in_sample_value;
  end

  // range compares and offsets
  assign diff_ext = {max_r[SampleW-1], max_r} - {min_r[SampleW-1], min_r};
  assign dmin_ext = {s0_val_r[SampleW-1], s0_val_r} - {min_r[SampleW-1], min_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
    s1_low_r  <= (min_r > max_r) || (s0_val_r <= min_r);
    s1_high_r <= s0_val_r > max_r;
    s1_diff_r <= diff_ext[SampleW-1:0];
    s1_dmin_r <= dmin_ext[SampleW-1:0];
  end

  // segment select: numerator and denominator of the fraction
  assign d_lo   = {1'b0, s1_diff_r[SampleW-1:1]};
  assign d_hi   = s1_diff_r - d_lo;
  assign d_up   = s1_dmin_r - d_lo;
  assign le_mid = s1_dmin_r <= d_lo;

  always_comb begin
    if (s1_low_r) begin
      s2_region = REGION_LOW;
    end else if (s1_high_r) begin
      s2_region = REGION_HIGH;
    end else if (le_mid) begin
      s2_region = REGION_LOWER;
    end else begin
      s2_region = REGION_UPPER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r[0] <= 1'b0;
    end else begin
      div_vld_r[0] <= s1_vld_r;
    end
    div_reg_r[0] <= s2_region;
    div_quo_r[0] <= '0;
    if (le_mid) begin
      div_rem_r[0] <= {2'b00, s1_dmin_r[SampleW-1:1]};
      div_bit_r[0] <= s1_dmin_r[0];
      div_den_r[0] <= d_lo;
    end else begin
      div_rem_r[0] <= {2'b00, d_up[SampleW-1:1]};
      div_bit_r[0] <= d_up[0];
      div_den_r[0] <= d_hi;
    end
  end

  // restoring divider, two quotient bits per stage (one in the last stage)
  for (genvar j = 0; j < DivStages; j++) begin : g_div
    logic [RemW-1:0]  rem_nxt;
    logic [FracW-1:0] quo_nxt;
    logic [RemW-1:0]  trial;

    always_comb begin
      rem_nxt = div_rem_r[j];
      quo_nxt = div_quo_r[j];
      trial   = '0;
      for (int k = 0; k < StepsPerStage; k++) begin
        if (j * StepsPerStage + k < DivSteps) begin
          trial = {rem_nxt[RemW-2:0],
                   (j * StepsPerStage + k == 0) ? div_bit_r[j] : 1'b0};
          if (trial >= {1'b0, div_den_r[j]}) begin
            rem_nxt = trial - {1'b0, div_den_r[j]};
            quo_nxt = {quo_nxt[FracW-2:0], 1'b1};
          end else begin
            rem_nxt = trial;
            quo_nxt = {quo_nxt[FracW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[j+1] <= 1'b0;
      end else begin
        div_vld_r[j+1] <= div_vld_r[j];
      end
      div_rem_r[j+1] <= rem_nxt;
      div_quo_r[j+1] <= quo_nxt;
      div_den_r[j+1] <= div_den_r[j];
      div_bit_r[j+1] <= div_bit_r[j];
      div_reg_r[j+1] <= div_reg_r[j];
    end
  end

  // blend: c0 + floor((c1 - c0) * f / 65536)
  always_comb begin
    logic [ColorW-1:0]        c0;
    logic [ColorW-1:0]        c1;
    logic signed [DeltaW-1:0] delta;
    c0 = color_c0(div_reg_r[DivStages], low_r, mid_r, high_r);
    c1 = color_c1(div_reg_r[DivStages], low_r, mid_r, high_r);
    delta = '0;
    for (int i = 0; i < NumChan; i++) begin
      delta = $signed({1'b0, c1[ChanW*(NumChan-1-i) +: ChanW]})
            - $signed({1'b0, c0[ChanW*(NumChan-1-i) +: ChanW]});
      mul_prod_nxt[i] = delta * $signed({1'b0, div_quo_r[DivStages]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= div_vld_r[DivStages];
    end
    mul_reg_r <= div_reg_r[DivStages];
    for (int i = 0; i < NumChan; i++) begin
      mul_prod_r[i] <= mul_prod_nxt[i];
    end
  end

  always_comb begin
    logic [ColorW-1:0]      c0;
    logic signed [SumW-1:0] sum;
    c0  = color_c0(mul_reg_r, low_r, mid_r, high_r);
    sum = '0;
    for (int i = 0; i < NumChan; i++) begin
      sum = $signed({{(SumW-ChanW){1'b0}}, c0[ChanW*(NumChan-1-i) +: ChanW]})
          + $signed({mul_prod_r[i][ProdW-1], mul_prod_r[i][ProdW-1:16]});
      out_chan_nxt[i] = sum[ChanW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= mul_vld_r;
    end
    out_reg_r <= mul_reg_r;
    for (int i = 0; i < NumChan; i++) begin
      out_chan_r[i] <= out_chan_nxt[i];
    end
  end

  assign out_valid  = out_vld_r;
  assign out_red    = out_chan_r[0];
  assign out_green  = out_chan_r[1];
  assign out_blue   = out_chan_r[2];
  assign out_region = out_reg_r;

endmodule
